[hw/rtl/bup25_pkg.sv]
// ----------------------------------------------------------------------------
// Bilinear 2.5x upscaler package
// Shared widths, register indexes, default sizes and the command record that
// the controller hands to the datapath.
// ----------------------------------------------------------------------------
package bup25_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 14;
  localparam int COL_W        = 12;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_W        = 13;
  localparam int WGT_W        = 5;
  localparam int SUM_W        = 13;
  localparam int RECIP_W      = 16;
  localparam int PROD_W       = SUM_W + RECIP_W;
  localparam int RECIP_SHIFT  = 20;

  localparam logic REG_IN_WIDTH  = 1'b0;
  localparam logic REG_IN_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd1024;

  localparam logic [SUM_W-1:0]   ROUND_BIAS = 13'd12;
  localparam logic [RECIP_W-1:0] RECIP_25   = 16'd41944;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [WGT_W-1:0]  wgt_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic       valid;
    row_t       row;
    col_t       col;
    logic [2:0] fx;
    logic [2:0] fy;
    logic       top_sel;
    logic       left_sel;
    logic       last;
  } bup25_cmd_t;

endpackage

[hw/rtl/bilinear_upscale_by_2_5.sv]
// ----------------------------------------------------------------------------
// Bilinear 2.5x upscaler, top level
// Enlarges one 8-bit plane, fed in raster order, by 2.5 in each direction.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, pixel) takes one request per pixel.
// Each request yields every output pixel whose four neighbors are now known,
// tagged with out_row and out_col, on the output channel (out_valid,
// out_ready); last marks the final result of a request. A request in the
// first row or the first column yields nothing, unless that row or column
// is also the last one.
// A request that yields results holds the block until the controller has
// issued them all, one output pixel per cycle while the datapath accepts
// them, into the shared interpolation pipeline, where each result passes
// stage 1, stage 2 and the output register in turn.
// The frame size is set through cfg_we, cfg_index and cfg_data, and must
// be changed only while the block is idle; the block does not enforce this.
// Reset puts the frame position at the origin and both size registers at
// 1024; the line buffer holds no valid data until the first row is in.
// While a result waits and out_ready is low the whole pipeline holds, and
// no new request is taken once the current one has results left to issue.
// ----------------------------------------------------------------------------
module bilinear_upscale_by_2_5 #(
  parameter int MAX_WIDTH  = bup25_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bup25_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bup25_pkg::CFG_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bup25_pkg::pix_t             pixel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bup25_pkg::row_t             out_row,
  output bup25_pkg::col_t             out_col,
  output bup25_pkg::pix_t             value,
  output logic                        last
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                  take;
  logic [CW-1:0]         addr;
  logic                  cmd_ready;
  bup25_pkg::bup25_cmd_t cmd;

  bup25_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .take      (take),
    .addr      (addr),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  bup25_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .take      (take),
    .addr      (addr),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .value     (value),
    .last      (last)
  );

endmodule

[hw/rtl/bup25_ctrl.sv]
// ----------------------------------------------------------------------------
// Upscaler controller
// Holds the configuration and the frame position, and walks the output
// pixels that each input request completes, one command per cycle while cmd_ready is high.
// ----------------------------------------------------------------------------
module bup25_ctrl #(
  parameter int MAX_WIDTH  = bup25_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bup25_pkg::DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [bup25_pkg::CFG_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic                           take,
  output logic [CW-1:0]                  addr,
  input  logic                           cmd_ready,
  output bup25_pkg::bup25_cmd_t          cmd
);

  localparam int RW = $clog2(MAX_HEIGHT);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_ISSUE = 1'b1;

  logic                                state;
  logic [bup25_pkg::WIDTH_REG_W-1:0]   in_width;
  logic [bup25_pkg::HEIGHT_REG_W-1:0]  in_height;
  logic [RW-1:0]                       row_count;
  logic [CW-1:0]                       col_count;
  logic [RW-1:0]                       cur_i;
  logic [CW-1:0]                       cur_j;
  logic                                row_edge;
  logic                                has_left;
  logic                                col_edge;
  logic                                rpass;
  logic                                cpass;
  logic [1:0]                          ry;
  logic [1:0]                          cx;

  logic [CW:0]   w_eff;
  logic [RW:0]   h_eff;
  logic          col_wrap;
  logic [RW:0]   i_bump;
  logic [RW-1:0] ia;
  logic [CW-1:0] ja;
  logic [CW:0]   j_inc;
  logic [RW:0]   i_inc;
  logic [RW-1:0] row_count_next;
  logic [CW-1:0] col_count_next;
  logic          up_now;
  logic          redge_now;
  logic          left_now;
  logic          cedge_now;
  logic          emits;

  logic [RW-1:0] k;
  logic [CW-1:0] m;
  logic [RW+2:0] r5;
  logic [CW+2:0] c5;
  logic [RW+2:0] row_full;
  logic [CW+2:0] col_full;
  logic          ry_last;
  logic          cx_last;
  logic          rpass_last;
  logic          cpass_last;

  always_comb begin
    if (in_width == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(in_width) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(in_width);
    end
    if (in_height == '0) begin
      h_eff = (RW+1)'(1);
    end else if (32'(in_height) > 32'(MAX_HEIGHT)) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(in_height);
    end
  end

  // Position of the arriving pixel, after any size change, and the next one.
  always_comb begin
    col_wrap = {1'b0, col_count} >= w_eff;
    ja       = col_wrap ? '0 : col_count;
    i_bump   = {1'b0, row_count} + (RW+1)'(col_wrap);
    ia       = (i_bump >= h_eff) ? '0 : i_bump[RW-1:0];
    j_inc    = {1'b0, ja} + (CW+1)'(1);
    i_inc    = {1'b0, ia} + (RW+1)'(1);
    if (j_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (i_inc >= h_eff) ? '0 : i_inc[RW-1:0];
    end else begin
      col_count_next = j_inc[CW-1:0];
      row_count_next = ia;
    end
    up_now    = ia != '0;
    redge_now = {1'b0, ia} == (h_eff - (RW+1)'(1));
    left_now  = ja != '0;
    cedge_now = {1'b0, ja} == (w_eff - (CW+1)'(1));
    emits     = (up_now | redge_now) & (left_now | cedge_now);
  end

  assign in_ready = state == S_IDLE;
  assign take     = in_valid & in_ready;
  assign addr     = ja;

  // Output coordinates of the current command and the loop end flags.
  always_comb begin
    k          = rpass ? cur_i : cur_i - RW'(1);
    m          = cpass ? cur_j : cur_j - CW'(1);
    r5         = (RW+3)'({k, 2'b00}) + (RW+3)'(k) + (RW+3)'(1);
    c5         = (CW+3)'({m, 2'b00}) + (CW+3)'(m) + (CW+3)'(1);
    row_full   = (RW+3)'(r5[RW+2:1]) + (RW+3)'(ry);
    col_full   = (CW+3)'(c5[CW+2:1]) + (CW+3)'(cx);
    ry_last    = ry == (k[0] ? 2'd1 : 2'd2);
    cx_last    = cx == (m[0] ? 2'd1 : 2'd2);
    rpass_last = rpass | ~row_edge;
    cpass_last = cpass | ~col_edge;

    cmd.valid    = state == S_ISSUE;
    cmd.row      = bup25_pkg::row_t'(row_full);
    cmd.col      = bup25_pkg::col_t'(col_full);
    cmd.fx       = {cx, m[0]};
    cmd.fy       = {ry, k[0]};
    cmd.top_sel  = rpass;
    cmd.left_sel = cpass;
    cmd.last     = ry_last & cx_last & rpass_last & cpass_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width  <= bup25_pkg::RESET_WIDTH;
      in_height <= bup25_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bup25_pkg::REG_IN_WIDTH:  in_width  <= cfg_data[bup25_pkg::WIDTH_REG_W-1:0];
        bup25_pkg::REG_IN_HEIGHT: in_height <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_count <= '0;
      col_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            row_count <= row_count_next;
            col_count <= col_count_next;
            cur_i     <= ia;
            cur_j     <= ja;
            row_edge  <= redge_now;
            has_left  <= left_now;
            col_edge  <= cedge_now;
            rpass     <= ~up_now;
            cpass     <= ~left_now;
            ry        <= '0;
            cx        <= '0;
            state     <= emits ? S_ISSUE : S_IDLE;
          end
        end
        S_ISSUE: begin
          if (cmd_ready) begin
            if (!cx_last) begin
              cx <= cx + 2'd1;
            end else begin
              cx <= '0;
              if (!cpass_last) begin
                cpass <= 1'b1;
              end else begin
                cpass <= ~has_left;
                if (!ry_last) begin
                  ry <= ry + 2'd1;
                end else begin
                  ry <= '0;
                  if (!rpass_last) begin
                    rpass <= 1'b1;
                  end else begin
                    state <= S_IDLE;
                  end
                end
              end
            end
          end
        end
      endcase
    end
  end

endmodule

[hw/rtl/bup25_dp.sv]
// ----------------------------------------------------------------------------
// Upscaler datapath
// Line buffer, 2x2 pixel window and a three-stage interpolation pipeline
// that ends in the output register.
// ----------------------------------------------------------------------------
module bup25_dp #(
  parameter int MAX_WIDTH = bup25_pkg::DEF_MAX_WIDTH,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bup25_pkg::pix_t       pixel,
  input  logic                  take,
  input  logic [CW-1:0]         addr,
  input  bup25_pkg::bup25_cmd_t cmd,
  output logic                  cmd_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bup25_pkg::row_t       out_row,
  output bup25_pkg::col_t       out_col,
  output bup25_pkg::pix_t       value,
  output logic                  last
);

  function automatic bup25_pkg::wgt_t wprod(input logic [2:0] a, input logic [2:0] b);
    return bup25_pkg::wgt_t'(a) * bup25_pkg::wgt_t'(b);
  endfunction

  bup25_pkg::pix_t line_mem [MAX_WIDTH];
  bup25_pkg::pix_t above;
  bup25_pkg::pix_t p00;
  bup25_pkg::pix_t p10;
  bup25_pkg::pix_t p11;

  logic            adv;
  logic [2:0]      wx0;
  logic [2:0]      wy0;

  logic            s1_valid;
  bup25_pkg::row_t s1_row;
  bup25_pkg::col_t s1_col;
  logic            s1_last;
  bup25_pkg::pix_t s1_tl;
  bup25_pkg::pix_t s1_tr;
  bup25_pkg::pix_t s1_bl;
  bup25_pkg::pix_t s1_br;
  bup25_pkg::wgt_t s1_wtl;
  bup25_pkg::wgt_t s1_wtr;
  bup25_pkg::wgt_t s1_wbl;
  bup25_pkg::wgt_t s1_wbr;

  logic            s2_valid;
  bup25_pkg::row_t s2_row;
  bup25_pkg::col_t s2_col;
  logic            s2_last;
  bup25_pkg::sum_t s2_sum;

  bup25_pkg::sum_t  biased;
  bup25_pkg::prod_t scaled;

  always_ff @(posedge clk) begin
    if (take) begin
      line_mem[addr] <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      above <= '0;
      p00   <= '0;
      p10   <= '0;
      p11   <= '0;
    end else if (take) begin
      above <= line_mem[addr];
      p00   <= above;
      p10   <= p11;
      p11   <= pixel;
    end
  end

  assign adv       = ~out_valid | out_ready;
  assign cmd_ready = adv;
  assign wx0       = 3'd5 - cmd.fx;
  assign wy0       = 3'd5 - cmd.fy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_row  <= cmd.row;
      s1_col  <= cmd.col;
      s1_last <= cmd.last;
      s1_tl   <= cmd.top_sel ? (cmd.left_sel ? p11 : p10) : (cmd.left_sel ? above : p00);
      s1_tr   <= cmd.top_sel ? p11 : above;
      s1_bl   <= cmd.left_sel ? p11 : p10;
      s1_br   <= p11;
      s1_wtl  <= wprod(wx0, wy0);
      s1_wtr  <= wprod(cmd.fx, wy0);
      s1_wbl  <= wprod(wx0, cmd.fy);
      s1_wbr  <= wprod(cmd.fx, cmd.fy);

      s2_row  <= s1_row;
      s2_col  <= s1_col;
      s2_last <= s1_last;
      s2_sum  <= bup25_pkg::sum_t'(s1_tl) * bup25_pkg::sum_t'(s1_wtl)
               + bup25_pkg::sum_t'(s1_tr) * bup25_pkg::sum_t'(s1_wtr)
               + bup25_pkg::sum_t'(s1_bl) * bup25_pkg::sum_t'(s1_wbl)
               + bup25_pkg::sum_t'(s1_br) * bup25_pkg::sum_t'(s1_wbr);

      out_row <= s2_row;
      out_col <= s2_col;
      last    <= s2_last;
      value   <= scaled[bup25_pkg::RECIP_SHIFT +: bup25_pkg::PIX_W];
    end
  end

  // Rounded division by 25 through a scaled reciprocal.
  assign biased = s2_sum + bup25_pkg::ROUND_BIAS;
  assign scaled = bup25_pkg::prod_t'(biased) * bup25_pkg::prod_t'(bup25_pkg::RECIP_25);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= cmd.valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

endmodule

[hw/rtl/bup25_checker.sv]
// ----------------------------------------------------------------------------
// Upscaler port checker
// Watches the top level's channels over time and flags broken behavior.
// ----------------------------------------------------------------------------
module bup25_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input bup25_pkg::row_t out_row,
  input bup25_pkg::col_t out_col,
  input bup25_pkg::pix_t value,
  input logic            last
);

  // After reset the block is empty and ready for a request.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not idle and empty after reset");

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_row) && $stable(out_col) && $stable(value) && $stable(last)))
    else $error("stalled result changed or dropped");

  // The block only leaves the ready state when a request is taken.
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (in_ready && !in_valid) |=> in_ready)
    else $error("input ready dropped without a request");

endmodule

bind bilinear_upscale_by_2_5 bup25_checker u_checker (.*);

[test/bilinear_upscale_by_2_5_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bilinear 2.5x upscaler testbench
// Streams pixel planes of many sizes through the upscaler and predicts every
// output pixel, with its coordinates and end-of-request flag, from a model of
// the line buffer and frame position. Results are checked in order. Both
// channels idle at random, frame sizes change between phases, and oversized
// registers clamp to the largest frame.
// ----------------------------------------------------------------------------
module bilinear_upscale_by_2_5_tb;

  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_ITEMS  = 220;

  typedef struct {
    bup25_pkg::row_t row;
    bup25_pkg::col_t col;
    bup25_pkg::pix_t val;
    logic            last;
  } upscaled_px_t;

  class upscale_scoreboard;
    bup25_pkg::pix_t                    line_store[bup25_pkg::DEF_MAX_WIDTH];
    bup25_pkg::pix_t                    left_cur;
    bup25_pkg::pix_t                    left_above;
    int unsigned                        row_pos;
    int unsigned                        col_pos;
    logic [bup25_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [bup25_pkg::HEIGHT_REG_W-1:0] height_reg;
    upscaled_px_t                       expected_q[$];
    int unsigned                        mismatches;

    function new();
      left_cur   = '0;
      left_above = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = bup25_pkg::RESET_WIDTH;
      height_reg = bup25_pkg::RESET_HEIGHT;
      mismatches = 0;
      foreach (line_store[idx]) line_store[idx] = '0;
    endfunction

    function void write_register(logic index, logic [bup25_pkg::CFG_W-1:0] data);
      if (index == bup25_pkg::REG_IN_WIDTH) begin
        width_reg = data[bup25_pkg::WIDTH_REG_W-1:0];
      end else begin
        height_reg = data[bup25_pkg::HEIGHT_REG_W-1:0];
      end
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > bup25_pkg::DEF_MAX_WIDTH) return bup25_pkg::DEF_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > bup25_pkg::DEF_MAX_HEIGHT) return bup25_pkg::DEF_MAX_HEIGHT;
      return height_reg;
    endfunction

    function bit at_frame_start();
      return row_pos == 0 && col_pos == 0;
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void note_pixel(bup25_pkg::pix_t px);
      int unsigned  w, h, i, j, above, a, b, r, c, k, m, fx, fy, sum, n_rows, n_cols;
      int unsigned  corner[2][2];
      int unsigned  row_k[2], row_top[2], row_bot[2];
      int unsigned  col_k[2], col_left[2], col_right[2];
      upscaled_px_t held;
      bit           have_held;
      have_held = 1'b0;
      w = eff_width();
      h = eff_height();
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      i = row_pos;
      j = col_pos;
      above = line_store[j];
      line_store[j] = px;
      corner[0][0] = left_above;
      corner[0][1] = above;
      corner[1][0] = left_cur;
      corner[1][1] = px;

      // Row 1 onward closes the band above; the last row also closes its own
      // band against a copy of itself. Columns work the same way.
      n_rows = 0;
      if (i >= 1) begin
        row_k[n_rows] = i - 1; row_top[n_rows] = 0; row_bot[n_rows] = 1; n_rows++;
      end
      if (i == h - 1) begin
        row_k[n_rows] = i; row_top[n_rows] = 1; row_bot[n_rows] = 1; n_rows++;
      end
      n_cols = 0;
      if (j >= 1) begin
        col_k[n_cols] = j - 1; col_left[n_cols] = 0; col_right[n_cols] = 1; n_cols++;
      end
      if (j == w - 1) begin
        col_k[n_cols] = j; col_left[n_cols] = 1; col_right[n_cols] = 1; n_cols++;
      end

      for (a = 0; a < n_rows; a++) begin
        k = row_k[a];
        for (r = (5 * k + 1) / 2; r <= (5 * k + 4) / 2; r++) begin
          fy = 2 * r - 5 * k;
          for (b = 0; b < n_cols; b++) begin
            m = col_k[b];
            for (c = (5 * m + 1) / 2; c <= (5 * m + 4) / 2; c++) begin
              fx = 2 * c - 5 * m;
              sum = corner[row_top[a]][col_left[b]] * (5 - fx) * (5 - fy)
                  + corner[row_top[a]][col_right[b]] * fx * (5 - fy)
                  + corner[row_bot[a]][col_left[b]] * (5 - fx) * fy
                  + corner[row_bot[a]][col_right[b]] * fx * fy;
              if (have_held) expected_q.push_back(held);
              held.row  = bup25_pkg::row_t'(r);
              held.col  = bup25_pkg::col_t'(c);
              held.val  = bup25_pkg::pix_t'((sum + 12) / 25);
              held.last = 1'b0;
              have_held = 1'b1;
            end
          end
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        expected_q.push_back(held);
      end

      left_cur   = px;
      left_above = bup25_pkg::pix_t'(above);
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void check_result(bup25_pkg::row_t row, bup25_pkg::col_t col,
                               bup25_pkg::pix_t val, logic lst);
      upscaled_px_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result: row %0d col %0d value %0d last %0b",
                                  row, col, val, lst));
      end else begin
        want = expected_q.pop_front();
        if (want.row !== row || want.col !== col || want.val !== val || want.last !== lst) begin
          report_mismatch($sformatf(
            {"mismatch: expected row %0d col %0d value %0d last %0b,",
             " got row %0d col %0d value %0d last %0b"},
            want.row, want.col, want.val, want.last, row, col, val, lst));
        end
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst       = 1'b1;
  logic                        cfg_we    = 1'b0;
  logic                        cfg_index = bup25_pkg::REG_IN_WIDTH;
  logic [bup25_pkg::CFG_W-1:0] cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  bup25_pkg::pix_t             pixel     = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  bup25_pkg::row_t             out_row;
  bup25_pkg::col_t             out_col;
  bup25_pkg::pix_t             value;
  logic                        last;

  bit src_gaps_on  = 1'b1;
  bit sink_gaps_on = 1'b1;
  bit hold_req     = 1'b0;

  upscale_scoreboard sb = new();

  bilinear_upscale_by_2_5 u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .value     (value),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap(bit enabled);
    int unsigned p;
    if (!enabled) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bup25_pkg::pix_t rand_pixel();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 15) return 8'h00;
    if (p < 30) return 8'hFF;
    return bup25_pkg::pix_t'($urandom_range(0, 255));
  endfunction

  function automatic logic [bup25_pkg::CFG_W-1:0] pick_width(int unsigned limit);
    int unsigned p, w;
    p = $urandom_range(0, 99);
    if (p < 65) w = $urandom_range(1, 8);
    else if (p < 75) w = 0;
    else if (p < 90) w = $urandom_range(9, 64);
    else w = $urandom_range(bup25_pkg::DEF_MAX_WIDTH - 8, 2047);
    if (w > limit) w = $urandom_range(0, limit);
    return {2'($urandom_range(0, 3)), (bup25_pkg::WIDTH_REG_W)'(w)};
  endfunction

  function automatic logic [bup25_pkg::CFG_W-1:0] pick_height();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 65) return (bup25_pkg::CFG_W)'($urandom_range(1, 6));
    if (p < 75) return '0;
    if (p < 88) return (bup25_pkg::CFG_W)'($urandom_range(7, 40));
    return (bup25_pkg::CFG_W)'($urandom_range(4000, 8191));
  endfunction

  task automatic send_pixel(input bup25_pkg::pix_t p);
    int unsigned gap;
    gap = pick_gap(src_gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(p);
  endtask

  task automatic send_run(input int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input logic [bup25_pkg::CFG_W-1:0] wdata,
                           input logic [bup25_pkg::CFG_W-1:0] hdata);
    cfg_we    <= 1'b1;
    cfg_index <= bup25_pkg::REG_IN_WIDTH;
    cfg_data  <= wdata;
    @(posedge clk);
    sb.write_register(bup25_pkg::REG_IN_WIDTH, wdata);
    cfg_index <= bup25_pkg::REG_IN_HEIGHT;
    cfg_data  <= hdata;
    @(posedge clk);
    sb.write_register(bup25_pkg::REG_IN_HEIGHT, hdata);
    cfg_we <= 1'b0;
  endtask

  initial begin : result_sink
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_row, out_col, value, last);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left = ($urandom_range(0, 99) < 25) ? pick_gap(sink_gaps_on) : 0;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned                 fed, n, phase;
    logic [bup25_pkg::CFG_W-1:0] wdata, hdata;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // A checkerboard of full-scale pixels, then the start of a second frame.
    set_frame(13'd3, 13'd3);
    for (int idx = 0; idx < 9; idx++) send_pixel((idx % 2) ? 8'h00 : 8'hFF);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    send_pixel(8'h0F);
    send_pixel(8'hF0);
    finish_phase();

    // The width shrinks mid-frame below the current column, with stray upper bits.
    set_frame(13'h1801, 13'd3);
    send_pixel(8'h80);
    send_pixel(8'h01);
    finish_phase();

    // A height of zero counts as one, which pulls the current row back to the top.
    set_frame(13'd1, 13'd0);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h7E);
    finish_phase();

    set_frame(13'd0, 13'd2);
    send_pixel(8'h3C);
    send_pixel(8'hC3);
    finish_phase();

    // Oversized registers clamp to the largest frame.
    set_frame(13'h07FF, 13'd2);
    send_run(16);
    finish_phase();
    set_frame(13'd1, 13'h1FFF);
    send_run(16);
    finish_phase();

    // A one-pixel frame wraps the position back to the origin.
    set_frame(13'd1, 13'd1);
    send_pixel(8'h5A);
    finish_phase();

    fed   = 0;
    phase = 0;
    while (fed < RANDOM_ITEMS) begin
      src_gaps_on  = ($urandom_range(0, 3) != 0);
      sink_gaps_on = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // In a one-pixel frame every request yields nine results.
        set_frame(13'd1, 13'd1);
        src_gaps_on = 1'b0;
        hold_req    = 1'b1;
        n           = 40;
      end else begin
        if ($urandom_range(0, 9) < 7) begin
          // Growing the width mid-frame would read line buffer entries never written.
          wdata = pick_width(sb.at_frame_start() ? 2047 : sb.eff_width());
          hdata = pick_height();
          set_frame(wdata, hdata);
        end
        n = $urandom_range(1, 40);
      end
      send_run(n);
      fed += n;
      finish_phase();
      phase++;
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
